// ===== rtl/framebuffer_pixel_access_unit_macros.svh =====
// Assertion macros shared by the framebuffer pixel access unit RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef FRAMEBUFFER_PIXEL_ACCESS_UNIT_MACROS_SVH
`define FRAMEBUFFER_PIXEL_ACCESS_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FPAU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fpau assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define FPAU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fpau assertion failed");

`endif

// ===== rtl/fpau_pkg.sv =====
// Package for the framebuffer pixel access unit: codes, field widths and shared types.
// Depends on nothing; used by fpau_codec and framebuffer_pixel_access_unit.
`timescale 1ns / 1ps
`default_nettype none

package fpau_pkg;

    // Opcodes carried on the input tuser.
    localparam logic [2:0] OP_READ_COLOR    = 3'd0;
    localparam logic [2:0] OP_WRITE_COLOR   = 3'd1;
    localparam logic [2:0] OP_READ_DEPTH    = 3'd2;
    localparam logic [2:0] OP_WRITE_DEPTH   = 3'd3;
    localparam logic [2:0] OP_READ_STENCIL  = 3'd4;
    localparam logic [2:0] OP_WRITE_STENCIL = 3'd5;

    // Color formats.
    localparam logic [2:0] CF_RGB565   = 3'd0;
    localparam logic [2:0] CF_RGBA4444 = 3'd1;
    localparam logic [2:0] CF_RGBA5551 = 3'd2;
    localparam logic [2:0] CF_RGB888   = 3'd3;
    localparam logic [2:0] CF_RGBA8888 = 3'd4;

    // Depth formats.
    localparam logic [1:0] DF_DEPTH16 = 2'd0;
    localparam logic [1:0] DF_DEPTH24 = 2'd1;
    localparam logic [1:0] DF_DEPTH32 = 2'd2;

    // Stencil formats.
    localparam logic [1:0] SF_ONE_BIT    = 2'd0;
    localparam logic [1:0] SF_FOUR_BITS  = 2'd1;
    localparam logic [1:0] SF_EIGHT_BITS = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SURFACE_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_COLOR_FORMAT   = 2'd1;
    localparam logic [1:0] CFG_DEPTH_FORMAT   = 2'd2;
    localparam logic [1:0] CFG_STENCIL_FORMAT = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [8:0] RST_SURFACE_WIDTH  = 9'd256;
    localparam logic [2:0] RST_COLOR_FORMAT   = CF_RGBA8888;
    localparam logic [1:0] RST_DEPTH_FORMAT   = DF_DEPTH16;
    localparam logic [1:0] RST_STENCIL_FORMAT = SF_EIGHT_BITS;

    // Port widths.
    localparam int IN_TDATA_W  = 88;
    localparam int OUT_TDATA_W = 72;
    localparam int CFG_DATA_W  = 9;

    typedef struct packed {
        logic [8:0] surface_width;
        logic [2:0] color_format;
        logic [1:0] depth_format;
        logic [1:0] stencil_format;
    } fpau_cfg_t;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [7:0]  x_coord;
        logic [7:0]  y_coord;
        logic [7:0]  in_red;
        logic [7:0]  in_green;
        logic [7:0]  in_blue;
        logic [7:0]  in_alpha;
        logic [31:0] in_depth;
        logic [7:0]  in_stencil;
    } fpau_item_t;

    typedef struct packed {
        logic [7:0]  out_red;
        logic [7:0]  out_green;
        logic [7:0]  out_blue;
        logic [7:0]  out_alpha;
        logic [31:0] out_depth;
        logic [7:0]  out_stencil;
    } fpau_result_t;

    // Write requests from the format codec toward the stores.
    typedef struct packed {
        logic        color_we;
        logic [31:0] color_wdata;
        logic        depth_we;
        logic [31:0] depth_wdata;
        logic        stencil_we;
        logic [7:0]  stencil_wdata;
        logic        has_result;
    } fpau_wr_t;

endpackage

`default_nettype wire

// ===== rtl/fpau_codec.sv =====
// Format codec: packs write data and unpacks stored words for color, depth and stencil.
// Depends on fpau_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fpau_codec (
    input  fpau_pkg::fpau_cfg_t    cfg,
    input  fpau_pkg::fpau_item_t   item,
    input  logic [2:0]             pix_sub,
    input  logic [31:0]            color_word,
    input  logic [31:0]            depth_word,
    input  logic [7:0]             stencil_byte,
    output fpau_pkg::fpau_result_t result,
    output fpau_pkg::fpau_wr_t     wr
);
    import fpau_pkg::*;

    logic [15:0] half;
    logic [31:0] depth_mask;
    logic [31:0] color_packed;
    logic        color_known;

    assign half = color_word[15:0];

    // Depth mask by format; an unknown format masks everything away.
    always_comb
    begin
        case (cfg.depth_format)
            DF_DEPTH16: depth_mask = 32'h0000_FFFF;
            DF_DEPTH24: depth_mask = 32'h00FF_FFFF;
            DF_DEPTH32: depth_mask = 32'hFFFF_FFFF;
            default:    depth_mask = 32'h0000_0000;
        endcase
    end

    // Color packing of the write data.
    always_comb
    begin
        color_known = 1'b1;
        case (cfg.color_format)
            CF_RGB565:
                color_packed = {16'h0000, item.in_red[7:3], item.in_green[7:2],
                                item.in_blue[7:3]};
            CF_RGBA4444:
                color_packed = {16'h0000, item.in_red[7:4], item.in_green[7:4],
                                item.in_blue[7:4], item.in_alpha[7:4]};
            CF_RGBA5551:
                color_packed = {16'h0000, item.in_red[7:3], item.in_green[7:3],
                                item.in_blue[7:3], item.in_alpha[7]};
            CF_RGB888:
                color_packed = {item.in_red, item.in_green, item.in_blue, 8'h00};
            CF_RGBA8888:
                color_packed = {item.in_red, item.in_green, item.in_blue, item.in_alpha};
            default:
            begin
                color_packed = 32'h0000_0000;
                color_known  = 1'b0;
            end
        endcase
    end

    // Result for read opcodes; fields the opcode does not produce stay zero.
    always_comb
    begin
        result = '0;
        case (item.opcode)
            OP_READ_COLOR:
            begin
                case (cfg.color_format)
                    CF_RGB565:
                    begin
                        result.out_red   = {half[15:11], half[15:13]};
                        result.out_green = {half[10:5], half[10:9]};
                        result.out_blue  = {half[4:0], half[4:2]};
                        result.out_alpha = 8'hFF;
                    end
                    CF_RGBA4444:
                    begin
                        result.out_red   = {half[15:12], half[15:12]};
                        result.out_green = {half[11:8], half[11:8]};
                        result.out_blue  = {half[7:4], half[7:4]};
                        result.out_alpha = {half[3:0], half[3:0]};
                    end
                    CF_RGBA5551:
                    begin
                        result.out_red   = {half[15:11], half[15:13]};
                        result.out_green = {half[10:6], half[10:8]};
                        result.out_blue  = {half[5:1], half[5:3]};
                        result.out_alpha = {8{half[0]}};
                    end
                    CF_RGB888:
                    begin
                        result.out_red   = color_word[31:24];
                        result.out_green = color_word[23:16];
                        result.out_blue  = color_word[15:8];
                        result.out_alpha = 8'hFF;
                    end
                    CF_RGBA8888:
                    begin
                        result.out_red   = color_word[31:24];
                        result.out_green = color_word[23:16];
                        result.out_blue  = color_word[15:8];
                        result.out_alpha = color_word[7:0];
                    end
                    default:
                    begin
                        result.out_red = 8'h00;
                    end
                endcase
            end
            OP_READ_DEPTH:
            begin
                result.out_depth = depth_word & depth_mask;
            end
            OP_READ_STENCIL:
            begin
                case (cfg.stencil_format)
                    SF_ONE_BIT:    result.out_stencil = {7'b0000000, stencil_byte[pix_sub]};
                    SF_FOUR_BITS:  result.out_stencil = pix_sub[0] ?
                                       {4'h0, stencil_byte[7:4]} : {4'h0, stencil_byte[3:0]};
                    SF_EIGHT_BITS: result.out_stencil = stencil_byte;
                    default:       result.out_stencil = 8'h00;
                endcase
            end
            default:
            begin
                result.out_stencil = 8'h00;
            end
        endcase
    end

    // Write requests; stencil writes merge into the byte that was read.
    always_comb
    begin
        wr               = '0;
        wr.color_wdata   = color_packed;
        wr.depth_wdata   = item.in_depth & depth_mask;
        wr.stencil_wdata = stencil_byte;
        case (item.opcode)
            OP_READ_COLOR, OP_READ_DEPTH, OP_READ_STENCIL:
            begin
                wr.has_result = 1'b1;
            end
            OP_WRITE_COLOR:
            begin
                wr.color_we = color_known;
            end
            OP_WRITE_DEPTH:
            begin
                // Only a known depth format has a nonzero mask.
                wr.depth_we = (depth_mask != 32'h0000_0000);
            end
            OP_WRITE_STENCIL:
            begin
                case (cfg.stencil_format)
                    SF_ONE_BIT:
                    begin
                        wr.stencil_we             = 1'b1;
                        wr.stencil_wdata[pix_sub] = item.in_stencil[0];
                    end
                    SF_FOUR_BITS:
                    begin
                        wr.stencil_we = 1'b1;
                        if (pix_sub[0])
                        begin
                            wr.stencil_wdata[7:4] = item.in_stencil[3:0];
                        end
                        else
                        begin
                            wr.stencil_wdata[3:0] = item.in_stencil[3:0];
                        end
                    end
                    SF_EIGHT_BITS:
                    begin
                        wr.stencil_we    = 1'b1;
                        wr.stencil_wdata = item.in_stencil;
                    end
                    default:
                    begin
                        wr.stencil_we = 1'b0;
                    end
                endcase
            end
            default:
            begin
                wr.has_result = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/framebuffer_pixel_access_unit.sv =====
// Top level of the framebuffer pixel access unit: stream ports, index pipeline and stores.
// Depends on fpau_pkg, fpau_codec and framebuffer_pixel_access_unit_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

// The unit serves one pixel transaction at a time: acceptance forms x + surface_width * y,
// ST_QUOT and ST_INDEX reduce it modulo PIXEL_COUNT by a reciprocal multiply and a subtract,
// ST_READ reads the synchronous stores, and ST_DONE unpacks the read result or writes the
// packed value back (stencil by read-modify-write). A read result sits in an output register,
// so the next item is taken while it waits; an item whose read result finds that register
// still full waits in ST_DONE until the register drains. Color and depth share one memory
// of PIXEL_COUNT 64-bit words, stencil has one of PIXEL_COUNT bytes; neither needs a
// clearing pass, and reading a location never written returns undefined data. Writes with
// an unknown format are dropped, and opcodes 6 and 7 give no result.
module framebuffer_pixel_access_unit #(
    parameter int PIXEL_COUNT = 65536
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // Input stream. s_tdata, low bit up: x_coord, y_coord, in_red, in_green, in_blue,
    // in_alpha, in_depth, in_stencil.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [fpau_pkg::IN_TDATA_W-1:0]  s_tdata,
    // s_tuser: opcode.
    input  logic [2:0]                       s_tuser,
    // Result stream. m_tdata, low bit up: out_red, out_green, out_blue, out_alpha,
    // out_depth, out_stencil.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [fpau_pkg::OUT_TDATA_W-1:0] m_tdata,
    // Configuration write channel.
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [1:0]                       cfg_index,
    input  logic [fpau_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import fpau_pkg::*;

`include "framebuffer_pixel_access_unit_macros.svh"

    localparam int IDX_W     = $clog2(PIXEL_COUNT);
    localparam int RAW_W     = 17;
    localparam int MUL_W     = RAW_W + 2;
    localparam int DIV_SHIFT = RAW_W + IDX_W;
    localparam logic [63:0] DIV_MUL =
        ((64'd1 << DIV_SHIFT) + 64'(PIXEL_COUNT) - 64'd1) / 64'(PIXEL_COUNT);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_QUOT,
        ST_INDEX,
        ST_READ,
        ST_DONE
    } state_t;

    state_t                    state_reg;
    fpau_cfg_t                 cfg_reg;
    logic                      m_tvalid_reg;
    logic                      m_tvalid_next;
    logic [OUT_TDATA_W-1:0]    m_tdata_reg;

    fpau_item_t                item_reg;
    fpau_item_t                item_next;
    logic [RAW_W-1:0]          raw_reg;
    logic [RAW_W-1:0]          raw_next;
    logic [RAW_W-1:0]          quot_reg;
    logic [RAW_W+MUL_W-1:0]    quot_prod;
    logic [RAW_W-1:0]          rem_full;
    logic [IDX_W-1:0]          idx_reg;
    logic [IDX_W-1:0]          stencil_addr;

    logic [63:0]               pix_mem [PIXEL_COUNT];
    logic [7:0]                stencil_mem [PIXEL_COUNT];
    logic [63:0]               pix_rdata_reg;
    logic [7:0]                stencil_rdata_reg;

    fpau_result_t              result;
    fpau_wr_t                  wr;
    logic                      in_fire;
    logic                      done_go;
    logic                      commit;

    // Handshake signals.
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // Unpack the input transaction into the item fields.
    always_comb
    begin
        item_next.opcode     = s_tuser;
        item_next.x_coord    = s_tdata[7:0];
        item_next.y_coord    = s_tdata[15:8];
        item_next.in_red     = s_tdata[23:16];
        item_next.in_green   = s_tdata[31:24];
        item_next.in_blue    = s_tdata[39:32];
        item_next.in_alpha   = s_tdata[47:40];
        item_next.in_depth   = s_tdata[79:48];
        item_next.in_stencil = s_tdata[87:80];
    end

    // Linear pixel index before wrapping.
    assign raw_next = RAW_W'(item_next.x_coord)
                    + RAW_W'(cfg_reg.surface_width * item_next.y_coord);

    // Quotient by reciprocal multiply, exact for every index below 2^RAW_W.
    assign quot_prod = raw_reg * DIV_MUL[MUL_W-1:0];

    // Remainder after removing whole multiples of the pixel count.
    assign rem_full = raw_reg - RAW_W'(quot_reg * RAW_W'(PIXEL_COUNT));

    // Byte address in the stencil store by packing density.
    always_comb
    begin
        case (cfg_reg.stencil_format)
            SF_ONE_BIT:   stencil_addr = idx_reg >> 3;
            SF_FOUR_BITS: stencil_addr = idx_reg >> 1;
            default:      stencil_addr = idx_reg;
        endcase
    end

    // Datapath registers of the item in flight.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_reg <= item_next;
            raw_reg  <= raw_next;
        end
        if (state_reg == ST_QUOT)
        begin
            quot_reg <= RAW_W'(quot_prod >> DIV_SHIFT);
        end
        if (state_reg == ST_INDEX)
        begin
            idx_reg <= IDX_W'(rem_full);
        end
    end

    // Color and depth store: one word per pixel, each half written on its own.
    always_ff @(posedge clk)
    begin
        if (commit && wr.color_we)
        begin
            pix_mem[idx_reg][31:0] <= wr.color_wdata;
        end
        if (commit && wr.depth_we)
        begin
            pix_mem[idx_reg][63:32] <= wr.depth_wdata;
        end
        pix_rdata_reg <= pix_mem[idx_reg];
    end

    // Stencil byte store.
    always_ff @(posedge clk)
    begin
        if (commit && wr.stencil_we)
        begin
            stencil_mem[stencil_addr] <= wr.stencil_wdata;
        end
        stencil_rdata_reg <= stencil_mem[stencil_addr];
    end

    // Format packing and unpacking.
    fpau_codec u_codec (
        .cfg          (cfg_reg),
        .item         (item_reg),
        .pix_sub      (idx_reg[2:0]),
        .color_word   (pix_rdata_reg[31:0]),
        .depth_word   (pix_rdata_reg[63:32]),
        .stencil_byte (stencil_rdata_reg),
        .result       (result),
        .wr           (wr)
    );

    // The last cycle completes unless a read result finds the output register full.
    assign done_go = (state_reg == ST_DONE) && (!wr.has_result || !m_tvalid_reg || m_tready);
    assign commit  = done_go;

    // The output register fills with a finished read and empties when its transaction is taken.
    assign m_tvalid_next = (done_go && wr.has_result) || (m_tvalid_reg && !m_tready);

    // Sequencer, configuration registers and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg              <= ST_IDLE;
            cfg_reg.surface_width  <= RST_SURFACE_WIDTH;
            cfg_reg.color_format   <= RST_COLOR_FORMAT;
            cfg_reg.depth_format   <= RST_DEPTH_FORMAT;
            cfg_reg.stencil_format <= RST_STENCIL_FORMAT;
            m_tvalid_reg           <= 1'b0;
            m_tdata_reg            <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_SURFACE_WIDTH:  cfg_reg.surface_width  <= cfg_data;
                    CFG_COLOR_FORMAT:   cfg_reg.color_format   <= cfg_data[2:0];
                    CFG_DEPTH_FORMAT:   cfg_reg.depth_format   <= cfg_data[1:0];
                    CFG_STENCIL_FORMAT: cfg_reg.stencil_format <= cfg_data[1:0];
                    default:            cfg_reg                <= cfg_reg;
                endcase
            end

            m_tvalid_reg <= m_tvalid_next;

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        state_reg <= ST_QUOT;
                    end
                end
                ST_QUOT:
                begin
                    state_reg <= ST_INDEX;
                end
                ST_INDEX:
                begin
                    state_reg <= ST_READ;
                end
                ST_READ:
                begin
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (done_go)
                    begin
                        state_reg <= ST_IDLE;
                        if (wr.has_result)
                        begin
                            m_tdata_reg  <= {result.out_stencil, result.out_depth,
                                             result.out_alpha, result.out_blue,
                                             result.out_green, result.out_red};
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // The unit is busy right after it takes a transaction.
    `FPAU_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_fire, !s_tready)
    // The wrapped index always lands inside the stores.
    `FPAU_ASSERT_IMPL(a_index_in_range, clk, rst_n, state_reg == ST_INDEX,
                      32'(rem_full) < 32'(PIXEL_COUNT))
    // A waiting result is never dropped or overwritten before it is taken.
    `FPAU_ASSERT_NEXT(a_result_kept, clk, rst_n, m_tvalid_reg && !m_tready,
                      m_tvalid_reg && $stable(m_tdata_reg))

endmodule

`default_nettype wire
